/* rtl/core/fbfa_pkg.sv */
// shared types and constants for the fixed block free list allocator
// no dependencies; imported by every module of the block
package fbfa_pkg;

   localparam int DEF_MAX_BLOCKS = 255;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BSIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CSIZE = 2'd2;

   // commands
   localparam logic [1:0] CMD_INIT    = 2'd0;
   localparam logic [1:0] CMD_ACQUIRE = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NO_FREE    = 2'd1;
   localparam logic [1:0] ST_BAD_ADDR   = 2'd2;
   localparam logic [1:0] ST_NOT_IN_USE = 2'd3;

   // address relation to the chunk
   localparam logic [1:0] REL_BELOW  = 2'd0;
   localparam logic [1:0] REL_INSIDE = 2'd1;
   localparam logic [1:0] REL_ABOVE  = 2'd2;

   // divider geometry
   localparam int DIV_NUM_W = 32;
   localparam int DIV_DEN_W = 16;
   localparam int DIV_STEPS = 2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] block_address;
      logic [7:0]  block_index;
      logic [7:0]  free_count;
      logic [7:0]  used_count;
      logic        now_empty;
      logic [1:0]  relation;
   } rsp_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
      logic [DIV_DEN_W-1:0] rem;
   } div_res_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CALC,
      S_CHECK,
      S_DIV,
      S_DONE
   } fsm_type;

endpackage

/* rtl/core/fixed_block_free_list_allocator_top.sv */
// fixed block allocator: free list of block links in a synchronous memory
// depends on fbfa_pkg and fbfa_div
//
//  channel | ports                       | direction | word
//  req     | req_valid req_ready req_data| in        | command and address
//  rsp     | rsp_valid rsp_ready rsp_data| out       | status, addresses, counts
//  csr     | csr_valid csr_ready csr_*   | in        | register index and data
//
// one item at a time: acquire, the unused command and a release outside the chunk go through
// calc, check and done; init runs the divider (two bits a cycle) before calc, check and done,
// and any other release runs it after check; done loads the result word and returns to idle
// reset restores link i -> i+1 through per-entry valid bits; no clearing pass
// a result waiting in the output register does not stop the next accept;
// the item then holds in its last state until rsp_ready frees the register
module fixed_block_free_list_allocator_top import fbfa_pkg::*; #(
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam logic [7:0] MAX_B8 = 8'(MAX_BLOCKS);

   // configuration registers
   logic [31:0] base_ff;
   logic [15:0] bsize_ff;
   logic [23:0] csize_ff;
   logic [15:0] bs_eff;

   // allocator state
   logic [7:0]            head_ff;
   logic [7:0]            free_ff;
   logic [7:0]            used_ff;
   logic [7:0]            count_ff;
   logic [MAX_BLOCKS-1:0] link_valid_ff;
   logic [7:0]            link_mem [MAX_BLOCKS];

   // per item working registers
   fsm_type     state_ff, state_in;
   logic [1:0]  cmd_ff;
   logic [31:0] addr_ff;
   logic [23:0] span_ff;
   logic [23:0] hoff_ff;
   logic [32:0] off_ff;
   logic [7:0]  link_q_ff;
   logic        lvalid_q_ff;
   rsp_type     res_ff;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;

   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_num;
   div_res_type          div_res;
   logic                 mem_we;
   logic                 out_load;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        wr_addr;
   logic [1:0]           rel_now;
   logic [7:0]           next_head;
   logic [7:0]           init_n;
   logic                 release_ok;
   logic                 q_in_range;

   assign csr_ready = 1'b1;
   assign bs_eff    = (bsize_ff == 16'd0) ? 16'd1 : bsize_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         bsize_ff <= 16'd1;
         csize_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BASE:  base_ff  <= csr_data;
            CSR_BSIZE: bsize_ff <= csr_data[15:0];
            CSR_CSIZE: csize_ff <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   // divider serves both the init block count and the release offset
   assign div_num = (state_ff == S_IDLE) ? {8'd0, csize_ff} : off_ff[31:0];

   fbfa_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (bs_eff),
      .res   (div_res)
   );

   assign rel_now = off_ff[32] ? REL_BELOW :
                    (off_ff[31:0] >= {8'd0, span_ff}) ? REL_ABOVE : REL_INSIDE;

   assign rd_addr   = (head_ff < MAX_B8) ? head_ff[AW-1:0] : '0;
   assign wr_addr   = div_res.quot[AW-1:0];
   assign next_head = (head_ff < MAX_B8) ? (lvalid_q_ff ? link_q_ff : head_ff + 8'd1)
                                         : 8'd0;
   assign init_n    = (div_res.quot > 32'(MAX_BLOCKS)) ? MAX_B8 : div_res.quot[7:0];
   assign q_in_range = div_res.quot < 32'(MAX_BLOCKS);
   assign release_ok = (cmd_ff == CMD_RELEASE) && (div_res.rem == '0) && (used_ff != 8'd0);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      div_start = 1'b0;
      mem_we    = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_data.cmd == CMD_INIT) begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end else begin
                  state_in = S_CALC;
               end
            end
         end
         S_CALC: state_in = S_CHECK;
         S_CHECK: begin
            if (cmd_ff == CMD_RELEASE && rel_now == REL_INSIDE) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            if (div_res.done) begin
               mem_we   = release_ok && q_in_range;
               // init goes on to work out the relation with the new block count
               state_in = (cmd_ff == CMD_INIT) ? S_CALC : S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // link memory: one read port for acquire, one write port for release
   always_ff @(posedge clock) begin
      if (mem_we) link_mem[wr_addr] <= head_ff;
      if (state_ff == S_CALC) link_q_ff <= link_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         free_ff       <= '0;
         used_ff       <= '0;
         count_ff      <= '0;
         link_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (out_load)       rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;

         if (state_ff == S_CHECK && cmd_ff == CMD_ACQUIRE && free_ff != 8'd0) begin
            head_ff <= next_head;
            free_ff <= free_ff - 8'd1;
            used_ff <= used_ff + 8'd1;
         end

         if (state_ff == S_DIV && div_res.done) begin
            if (cmd_ff == CMD_INIT) begin
               head_ff       <= '0;
               count_ff      <= init_n;
               free_ff       <= init_n;
               used_ff       <= '0;
               link_valid_ff <= '0;
            end else if (release_ok) begin
               head_ff <= div_res.quot[7:0];
               free_ff <= free_ff + 8'd1;
               used_ff <= used_ff - 8'd1;
               if (q_in_range) link_valid_ff[wr_addr] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff  <= req_data.cmd;
         addr_ff <= req_data.address;
         res_ff  <= '0;
      end

      if (state_ff == S_CALC) begin
         span_ff     <= {8'd0, bs_eff} * {16'd0, count_ff};
         hoff_ff     <= {8'd0, bs_eff} * {16'd0, head_ff};
         off_ff      <= {1'b0, addr_ff} - {1'b0, base_ff};
         lvalid_q_ff <= link_valid_ff[rd_addr];
      end

      if (state_ff == S_CHECK) begin
         res_ff.relation <= rel_now;
         if (cmd_ff == CMD_ACQUIRE) begin
            if (free_ff == 8'd0) begin
               res_ff.status <= ST_NO_FREE;
            end else begin
               res_ff.block_address <= base_ff + {8'd0, hoff_ff};
               res_ff.block_index   <= head_ff;
            end
         end else if (cmd_ff == CMD_RELEASE && rel_now != REL_INSIDE) begin
            res_ff.status <= ST_BAD_ADDR;
         end
      end

      if (state_ff == S_DIV && div_res.done && cmd_ff == CMD_RELEASE) begin
         priority if (div_res.rem != '0) begin
            res_ff.status <= ST_BAD_ADDR;
         end else if (used_ff == 8'd0) begin
            res_ff.status <= ST_NOT_IN_USE;
         end else begin
            res_ff.block_index <= div_res.quot[7:0];
            res_ff.now_empty   <= (used_ff == 8'd1);
         end
      end

      // counts come from the live state, everything else from the working word
      if (out_load) begin
         rsp_ff <= {res_ff.status, res_ff.block_address, res_ff.block_index,
                    free_ff, used_ff, res_ff.now_empty, res_ff.relation};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/core/fbfa_div.sv */
// iterative restoring divider, DIV_STEPS quotient bits per cycle
// depends on fbfa_pkg
module fbfa_div import fbfa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output div_res_type          res
);

   localparam int CYCLES = DIV_NUM_W / DIV_STEPS;
   localparam int CNT_W  = $clog2(CYCLES + 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [DIV_NUM_W-1:0] quot_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;

   logic [DIV_NUM_W-1:0] quot_in;
   logic [DIV_DEN_W-1:0] rem_in;
   logic [DIV_DEN_W:0]   trial;

   // dividend bits shift out of the top of quot while quotient bits enter below
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      trial   = '0;
      for (int s = 0; s < DIV_STEPS; s++) begin
         trial = {rem_in, quot_in[DIV_NUM_W-1]};
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = DIV_DEN_W'(trial - {1'b0, den_ff});
            quot_in = {quot_in[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[DIV_DEN_W-1:0];
            quot_in = {quot_in[DIV_NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == CNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(CYCLES);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= num;
         rem_ff  <= '0;
         den_ff  <= den;
      end else if (busy_ff) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   assign res.done = done_ff;
   assign res.quot = quot_ff;
   assign res.rem  = rem_ff;

endmodule

/* rtl/core/fbfa_chk.sv */
// port level checks for the allocator top, attached by bind
// depends on fbfa_pkg and fixed_block_free_list_allocator_top
module fbfa_chk import fbfa_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // one item at a time: no accept right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word accepted while an item is in flight");

   // errors carry no block
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |->
      rsp_data.block_address == '0 && rsp_data.block_index == '0 && !rsp_data.now_empty)
      else $error("error result carries block data");

   // now_empty means nothing left in use
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.now_empty |-> rsp_data.used_count == 8'd0)
      else $error("now_empty with blocks still in use");

   // no result straight out of reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind fixed_block_free_list_allocator_top fbfa_chk u_fbfa_chk (.*);

/* tb/tb_fixed_block_free_list_allocator_top.sv */
// self-checking testbench for fixed_block_free_list_allocator_top
// depends on fbfa_pkg and the allocator rtl; mirrors the free list to predict each result word
`timescale 1ns / 1ps

module tb_fixed_block_free_list_allocator_top;
   import fbfa_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // register mirror and free list model
   logic [31:0] cfg_base = 32'd0;
   logic [15:0] cfg_bsize = 16'd1;
   logic [23:0] cfg_csize = 24'd0;
   logic [7:0] link_tab [DEF_MAX_BLOCKS];
   logic [7:0] head_blk, free_blks, used_blks, blk_total;

   req_type pending_cmds [$];
   rsp_type predicted_results [$];
   rsp_type predicted, want;

   // stimulus-side view of the list, only used to steer releases
   int gen_free [$];
   int gen_held [$];
   int gen_count = 0;

   int issued = 0, answered = 0, errors = 0;
   int n_settings = 0, n_granted = 0, n_released = 0, n_refused = 0;
   int gap_left = 0, burst_left = 0;
   int hold_left = 0, mode_left = 0;
   bit held_off = 1'b0;
   rx_mode_type rx_mode = RX_ALWAYS;

   fixed_block_free_list_allocator_top DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   function automatic logic [15:0] eff_block_size();
      return (cfg_bsize == 16'd0) ? 16'd1 : cfg_bsize;
   endfunction

   function automatic logic [1:0] addr_relation(logic [31:0] addr);
      logic [47:0] chunk_end;
      chunk_end = {16'd0, cfg_base} + 48'(eff_block_size()) * 48'(blk_total);
      if (addr < cfg_base)
         return REL_BELOW;
      if ({16'd0, addr} >= chunk_end)
         return REL_ABOVE;
      return REL_INSIDE;
   endfunction

   function automatic rsp_type apply_command(req_type r);
      rsp_type o;
      logic [15:0] bs;
      logic [31:0] off, idx, n;
      int i;
      o = '0;
      bs = eff_block_size();
      case (r.cmd)
         CMD_INIT: begin
            n = cfg_csize / bs;
            if (n > DEF_MAX_BLOCKS)
               n = DEF_MAX_BLOCKS;
            for (i = 0; i < DEF_MAX_BLOCKS; i++)
               link_tab[i] = 8'(i + 1);
            head_blk = 8'd0;
            blk_total = n[7:0];
            free_blks = n[7:0];
            used_blks = 8'd0;
         end
         CMD_ACQUIRE: begin
            if (free_blks == 8'd0) begin
               o.status = ST_NO_FREE;
            end else begin
               o.block_address = cfg_base + head_blk * bs;
               o.block_index = head_blk;
               head_blk = (head_blk < DEF_MAX_BLOCKS) ? link_tab[head_blk] : 8'd0;
               free_blks = free_blks - 8'd1;
               used_blks = used_blks + 8'd1;
            end
         end
         CMD_RELEASE: begin
            off = r.address - cfg_base;
            // range and alignment are checked before the in-use count
            if (addr_relation(r.address) != REL_INSIDE || (off % bs) != 0) begin
               o.status = ST_BAD_ADDR;
            end else if (used_blks == 8'd0) begin
               o.status = ST_NOT_IN_USE;
            end else begin
               idx = off / bs;
               link_tab[idx] = head_blk;
               head_blk = idx[7:0];
               o.block_index = idx[7:0];
               free_blks = free_blks + 8'd1;
               used_blks = used_blks - 8'd1;
               o.now_empty = (used_blks == 8'd0);
            end
         end
         default: ;
      endcase
      o.free_count = free_blks;
      o.used_count = used_blks;
      o.relation = addr_relation(r.address);
      return o;
   endfunction

   task automatic report_mismatch(string msg);
      errors++;
      $display("%0t ns: word %0d: %s", $time, answered, msg);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
      if (got !== exp_val)
         report_mismatch($sformatf("%s is %0h, %0h predicted", name, got, exp_val));
   endtask

   // request driver: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         for (int i = 0; i < DEF_MAX_BLOCKS; i++)
            link_tab[i] = 8'(i + 1);
         head_blk = 8'd0;
         free_blks = 8'd0;
         used_blks = 8'd0;
         blk_total = 8'd0;
      end else begin
         if (req_valid && req_ready) begin
            predicted = apply_command(req_data);
            predicted_results.push_back(predicted);
            if (predicted.status != ST_OK)
               n_refused++;
            else if (req_data.cmd == CMD_ACQUIRE)
               n_granted++;
            else if (req_data.cmd == CMD_RELEASE)
               n_released++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               req_valid <= 1'b1;
               req_data <= pending_cmds.pop_front();
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 16);
                  if ($urandom_range(3) == 0)
                     gap_left = 0;
                  else
                     gap_left = $urandom_range(1, ($urandom_range(7) == 0) ? 30 : 4);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               report_mismatch("result word with nothing predicted");
            end else begin
               want = predicted_results.pop_front();
               check_field("status", 32'(rsp_data.status), 32'(want.status));
               check_field("block_address", rsp_data.block_address, want.block_address);
               check_field("block_index", 32'(rsp_data.block_index),
                           32'(want.block_index));
               check_field("free_count", 32'(rsp_data.free_count), 32'(want.free_count));
               check_field("used_count", 32'(rsp_data.used_count), 32'(want.used_count));
               check_field("now_empty", 32'(rsp_data.now_empty), 32'(want.now_empty));
               check_field("relation", 32'(rsp_data.relation), 32'(want.relation));
               answered++;
            end
            // one long hold-off so the block backs up and stalls its input
            if (answered == 300 && !held_off) begin
               held_off = 1'b1;
               hold_left = 500;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               rx_mode = rx_mode_type'($urandom_range(3));
               mode_left = $urandom_range(20, 200);
            end else begin
               mode_left--;
            end
            case (rx_mode)
               RX_ALWAYS: rsp_ready <= 1'b1;
               RX_HALF:   rsp_ready <= 1'($urandom_range(1));
               RX_SPARSE: rsp_ready <= ($urandom_range(7) == 0);
               default:   rsp_ready <= ~rsp_ready;
            endcase
         end
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_BASE:  cfg_base = data;
         CSR_BSIZE: cfg_bsize = data[15:0];
         CSR_CSIZE: cfg_csize = data[23:0];
         default: ;
      endcase
   endtask

   // upper bits beyond each register's width carry junk
   task automatic set_chunk(logic [31:0] base, logic [15:0] bsize, logic [23:0] csize);
      write_reg(CSR_BASE, base);
      write_reg(CSR_BSIZE, {16'($urandom), bsize});
      write_reg(CSR_CSIZE, {8'($urandom), csize});
      n_settings++;
   endtask

   task automatic queue_cmd(logic [1:0] cmd, logic [31:0] addr);
      req_type r;
      logic [15:0] bs;
      logic [31:0] n;
      int k;
      bs = eff_block_size();
      r.cmd = cmd;
      r.address = addr;
      pending_cmds.push_back(r);
      issued++;
      case (cmd)
         CMD_INIT: begin
            n = cfg_csize / bs;
            gen_count = (n > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : int'(n);
            gen_free = {};
            gen_held = {};
            for (k = 0; k < gen_count; k++)
               gen_free.push_back(k);
         end
         CMD_ACQUIRE: begin
            if (gen_free.size() > 0)
               gen_held.push_back(gen_free.pop_front());
         end
         CMD_RELEASE: begin
            for (k = 0; k < gen_held.size(); k++) begin
               if ({16'd0, addr} == {16'd0, cfg_base} + 48'(gen_held[k]) * 48'(bs)) begin
                  gen_free.push_front(gen_held[k]);
                  gen_held.delete(k);
                  break;
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic release_held();
      int k;
      if (gen_held.size() > 0) begin
         k = $urandom_range(gen_held.size() - 1);
         queue_cmd(CMD_RELEASE, cfg_base + gen_held[k] * eff_block_size());
      end
   endtask

   task automatic add_noise();
      logic [15:0] bs;
      bs = eff_block_size();
      case ($urandom_range(5))
         0: queue_cmd(CMD_RELEASE, cfg_base + $urandom_range(gen_count) * bs
                                   + ((bs > 1) ? $urandom_range(1, bs - 1) : 0));
         1: queue_cmd(CMD_RELEASE, (cfg_base == 0) ? 32'd0 : $urandom_range(cfg_base - 1));
         2: queue_cmd(CMD_RELEASE, cfg_base + gen_count * bs + $urandom_range(3));
         3: queue_cmd(CMD_RELEASE, $urandom);
         4: queue_cmd(CMD_UNUSED, $urandom);
         // aligned block that may already be free
         default: queue_cmd(CMD_RELEASE,
                            cfg_base + $urandom_range((gen_count > 0) ? gen_count - 1 : 0) * bs);
      endcase
   endtask

   task automatic run_random(int n, int acquire_pct);
      int pick;
      repeat (n) begin
         pick = $urandom_range(99);
         if (pick < 3)
            queue_cmd(CMD_INIT, $urandom);
         else if (pick < 3 + acquire_pct)
            queue_cmd(CMD_ACQUIRE, $urandom);
         else if (pick < 90 && gen_held.size() > 0)
            release_held();
         else
            add_noise();
      end
   endtask

   task automatic wait_drained();
      while (answered != issued)
         @(posedge clock);
   endtask

   task automatic random_chunk();
      logic [15:0] bs;
      int cnt;
      bs = ($urandom_range(4) == 0) ? 16'($urandom_range(65, 65535)) : 16'($urandom_range(1, 64));
      cnt = ($urandom_range(5) == 0) ? $urandom_range(25, 255) : $urandom_range(1, 24);
      set_chunk($urandom, bs, 24'(bs * cnt + $urandom_range(bs - 1)));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: four blocks of 16 bytes at 0x1000, five spare bytes
      set_chunk(32'h0000_1000, 16'd16, 24'd69);
      queue_cmd(CMD_ACQUIRE, 32'h0000_0000);
      queue_cmd(CMD_RELEASE, 32'hFFFF_FFFF);
      queue_cmd(CMD_INIT, 32'h0000_0FFF);
      queue_cmd(CMD_RELEASE, 32'h0000_1000);   // nothing in use yet
      repeat (4) queue_cmd(CMD_ACQUIRE, 32'h0000_1010);
      queue_cmd(CMD_ACQUIRE, 32'h0000_103F);   // list empty
      queue_cmd(CMD_RELEASE, 32'h0000_1011);   // misaligned
      queue_cmd(CMD_RELEASE, 32'h0000_0FFF);   // below the chunk
      queue_cmd(CMD_RELEASE, 32'h0000_1040);   // exactly at the end
      queue_cmd(CMD_RELEASE, 32'h0000_1010);
      queue_cmd(CMD_RELEASE, 32'h0000_1010);   // same block twice goes undetected
      queue_cmd(CMD_UNUSED, 32'hFFFF_FFFF);
      queue_cmd(CMD_RELEASE, 32'h0000_1000);
      queue_cmd(CMD_RELEASE, 32'h0000_1030);   // last one in use
      queue_cmd(CMD_RELEASE, 32'h0000_1020);
      repeat (3) queue_cmd(CMD_ACQUIRE, 32'h0000_0000);
      wait_drained();

      // empty chunk
      set_chunk(32'd0, 16'd1, 24'd0);
      queue_cmd(CMD_INIT, $urandom);
      run_random(20, 40);
      wait_drained();

      // full table: drain all 255 blocks, then give some back
      set_chunk(32'd0, 16'd1, 24'hFF_FFFF);
      queue_cmd(CMD_INIT, $urandom);
      repeat (256) queue_cmd(CMD_ACQUIRE, $urandom);
      repeat (40) release_held();
      run_random(20, 40);
      wait_drained();

      // zero block size counts as one; chunk ends at the top of the address space
      set_chunk(32'hFFFF_FF00, 16'd0, 24'd300);
      queue_cmd(CMD_INIT, 32'hFFFF_FFFF);
      run_random(40, 45);
      wait_drained();

      // largest sizes; acquired addresses wrap past 32 bits
      set_chunk(32'hFFFF_FFF0, 16'hFFFF, 24'hFF_FFFF);
      queue_cmd(CMD_INIT, $urandom);
      run_random(30, 50);
      wait_drained();

      // new base and block size while the latched block count stays
      set_chunk($urandom, 16'($urandom_range(1, 32)), 24'($urandom));
      run_random(30, 35);
      wait_drained();

      while (issued < 930) begin
         random_chunk();
         queue_cmd(CMD_INIT, $urandom);
         run_random($urandom_range(50, 110), $urandom_range(25, 55));
         wait_drained();
      end

      repeat (60) @(posedge clock);
      if (predicted_results.size() != 0)
         report_mismatch($sformatf("%0d predicted words never came", predicted_results.size()));
      $display("covered %0d commands over %0d register settings", issued, n_settings);
      $display("%0d blocks granted, %0d released, %0d refused with an error status",
               n_granted, n_released, n_refused);
      if (errors == 0)
         $display("fixed_block_free_list_allocator_top test passed");
      else
         $display("fixed_block_free_list_allocator_top test failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("fixed_block_free_list_allocator_top test failed");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/fbfa_pkg.sv
rtl/core/fbfa_div.sv
rtl/core/fixed_block_free_list_allocator_top.sv
rtl/core/fbfa_chk.sv
tb/tb_fixed_block_free_list_allocator_top.sv
